FILE: rtl/bcs_pkg.sv
// Package for the best-candidate point sampler.
// Holds the register map, reset values, widths, the sequencer states and the scan control struct.
// Depends on nothing; every other file of the block imports it.
package bcs_pkg;

	localparam int MAX_POINTS_DEF     = 1024;
	localparam int COORD_BITS_DEF     = 12;
	localparam int MAX_CANDIDATES_DEF = 64;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam int WANTED_BITS = 11;
	localparam int CANDS_BITS  = 7;
	localparam int HALF_BITS   = 11;

	localparam logic [1:0] REG_POINTS_WANTED = 2'd0;
	localparam logic [1:0] REG_CANDS_ROUND   = 2'd1;
	localparam logic [1:0] REG_HALF_WIDTH    = 2'd2;
	localparam logic [1:0] REG_HALF_HEIGHT   = 2'd3;

	localparam logic [WANTED_BITS-1:0] WANTED_RST = 11'd64;
	localparam logic [CANDS_BITS-1:0]  CANDS_RST  = 7'd10;
	localparam logic [HALF_BITS-1:0]   HALF_W_RST = 11'd512;
	localparam logic [HALF_BITS-1:0]   HALF_H_RST = 11'd384;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_CAND  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic issue;
		logic last;
	} scan_ctl_t;

endpackage

FILE: rtl/bcs_point_mem.sv
// Point store of the best-candidate sampler: one write port and one registered read port.
// Each entry holds the x and y coordinates of one accepted point.
// Depends on bcs_pkg.
module bcs_point_mem
	import bcs_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int ADDR_W    = $clog2(MAX_POINTS)
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [ADDR_W-1:0]            wr_addr,
	input  logic signed [COORD_BITS-1:0] wr_x,
	input  logic signed [COORD_BITS-1:0] wr_y,
	input  logic                         rd_en,
	input  logic [ADDR_W-1:0]            rd_addr,
	output logic signed [COORD_BITS-1:0] rd_x,
	output logic signed [COORD_BITS-1:0] rd_y
);

	logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
	logic [2*COORD_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_x, wr_y};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_x = signed'(rd_data_q[2*COORD_BITS-1:COORD_BITS]);
	assign rd_y = signed'(rd_data_q[COORD_BITS-1:0]);

endmodule

FILE: rtl/bcs_dist.sv
// Nearest-point distance pipeline of the best-candidate sampler.
// Takes one stored point per cycle from the point store and keeps the smallest squared distance.
// Depends on bcs_pkg.
module bcs_dist
	import bcs_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int SQ_W      = 2*COORD_BITS + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  scan_ctl_t                    ctl,
	input  logic signed [COORD_BITS-1:0] cand_x,
	input  logic signed [COORD_BITS-1:0] cand_y,
	input  logic signed [COORD_BITS-1:0] rd_x,
	input  logic signed [COORD_BITS-1:0] rd_y,
	output logic [SQ_W-1:0]              min_sq,
	output logic                         min_done
);

	localparam int DX_W = COORD_BITS + 1;

	logic                     v_s1, last_s1;
	logic                     v_s2, last_s2;
	logic                     v_s3, last_s3;
	logic signed [DX_W-1:0]   dx_s2, dy_s2;
	logic [2*COORD_BITS-1:0]  sqx_s3, sqy_s3;
	logic signed [2*DX_W-1:0] prod_x, prod_y;
	logic [SQ_W-1:0]          sum;
	logic [SQ_W-1:0]          min_q;
	logic                     done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			v_s3    <= 1'b0;
			last_s3 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1    <= ctl.issue;
			last_s1 <= ctl.issue & ctl.last;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			v_s3    <= v_s2;
			last_s3 <= last_s2;
			done_q  <= v_s3 & last_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2 <= DX_W'(cand_x) - DX_W'(rd_x);
		dy_s2 <= DX_W'(cand_y) - DX_W'(rd_y);
	end

	assign prod_x = dx_s2 * dx_s2;
	assign prod_y = dy_s2 * dy_s2;

	always_ff @(posedge clk) begin
		sqx_s3 <= prod_x[2*COORD_BITS-1:0];
		sqy_s3 <= prod_y[2*COORD_BITS-1:0];
	end

	assign sum = SQ_W'(sqx_s3) + SQ_W'(sqy_s3);

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			min_q <= '1;
		end else if (v_s3 && (sum < min_q)) begin
			min_q <= sum;
		end
	end

	assign min_sq   = min_q;
	assign min_done = done_q;

endmodule

FILE: rtl/bcs_ctrl.sv
// Sequencer of the best-candidate sampler: clamping, store scan, round bookkeeping and results.
// Drives the point store and the distance pipeline and holds the result registers.
// Depends on bcs_pkg.
module bcs_ctrl
	import bcs_pkg::*;
#(
	parameter int MAX_POINTS     = MAX_POINTS_DEF,
	parameter int COORD_BITS     = COORD_BITS_DEF,
	parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
	localparam int ADDR_W        = $clog2(MAX_POINTS),
	localparam int CNT_W         = $clog2(MAX_POINTS + 1),
	localparam int RND_W         = $clog2(MAX_CANDIDATES + 1),
	localparam int SQ_W          = 2*COORD_BITS + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         kind,
	input  logic signed [COORD_BITS-1:0] cand_x,
	input  logic signed [COORD_BITS-1:0] cand_y,
	output logic                         busy,
	input  logic [CNT_W-1:0]             wanted_eff,
	input  logic [RND_W-1:0]             cands_eff,
	input  logic [HALF_BITS-1:0]         half_width,
	input  logic [HALF_BITS-1:0]         half_height,
	output scan_ctl_t                    scan_ctl,
	output logic [ADDR_W-1:0]            rd_addr,
	output logic                         wr_en,
	output logic [ADDR_W-1:0]            wr_addr,
	output logic signed [COORD_BITS-1:0] wr_x,
	output logic signed [COORD_BITS-1:0] wr_y,
	output logic signed [COORD_BITS-1:0] sel_x,
	output logic signed [COORD_BITS-1:0] sel_y,
	input  logic [SQ_W-1:0]              min_sq,
	input  logic                         min_done,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic [ADDR_W-1:0]            point_index,
	output logic                         last_point
);

	localparam int EXT_W = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS) + 2;
	localparam logic signed [EXT_W-1:0] TOP_E = EXT_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);

	function automatic logic signed [COORD_BITS-1:0] clamp_c(
		input logic signed [COORD_BITS-1:0] v,
		input logic [HALF_BITS-1:0]         half
	);
		logic signed [EXT_W-1:0] ve;
		logic signed [EXT_W-1:0] he;
		logic signed [EXT_W-1:0] lim;
		logic signed [EXT_W-1:0] res;
		ve  = EXT_W'(v);
		he  = signed'(EXT_W'(half));
		lim = (he > TOP_E) ? TOP_E : he;
		if (ve > lim) begin
			res = lim;
		end else if (ve < -lim) begin
			res = -lim;
		end else begin
			res = ve;
		end
		return res[COORD_BITS-1:0];
	endfunction

	state_t                       state_q, state_d;
	logic [CNT_W-1:0]             count_q;
	logic [RND_W-1:0]             round_q;
	logic                         best_none_q;
	logic [SQ_W-1:0]              best_sq_q;
	logic signed [COORD_BITS-1:0] best_x_q, best_y_q;
	logic                         run_q;
	logic signed [COORD_BITS-1:0] cand_x_q, cand_y_q;
	logic signed [COORD_BITS-1:0] emit_x_q, emit_y_q;
	logic [ADDR_W-1:0]            addr_q;
	logic                         done_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [ADDR_W-1:0]            pidx_q;
	logic                         last_q;

	logic                         item_acc;
	logic                         cand_go;
	logic signed [COORD_BITS-1:0] clamp_x, clamp_y;
	logic                         scan_last;
	logic                         take;
	logic [RND_W-1:0]             round_nx;
	logic                         round_end;
	logic [CNT_W-1:0]             count_nx;
	logic                         is_last;

	assign item_acc  = start & ~busy;
	assign cand_go   = item_acc & (kind == KIND_CAND) & run_q;
	assign clamp_x   = clamp_c(cand_x, half_width);
	assign clamp_y   = clamp_c(cand_y, half_height);
	assign scan_last = (CNT_W'(addr_q) + CNT_W'(1)) == count_q;
	assign take      = best_none_q | (min_sq > best_sq_q);
	assign round_nx  = round_q + RND_W'(1);
	assign round_end = round_nx >= cands_eff;
	assign count_nx  = count_q + CNT_W'(1);
	assign is_last   = count_nx >= wanted_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		busy           = 1'b1;
		scan_ctl.clear = 1'b0;
		scan_ctl.issue = 1'b0;
		scan_ctl.last  = 1'b0;
		wr_en          = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (cand_go) begin
					if (count_q == '0) begin
						state_d = ST_EMIT;
					end else begin
						state_d        = ST_SCAN;
						scan_ctl.clear = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				scan_ctl.issue = 1'b1;
				scan_ctl.last  = scan_last;
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (min_done) begin
					state_d = round_end ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				wr_en   = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			round_q     <= '0;
			best_none_q <= 1'b1;
			best_sq_q   <= '0;
			best_x_q    <= '0;
			best_y_q    <= '0;
			run_q       <= 1'b0;
			addr_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_acc && (kind == KIND_START)) begin
						count_q     <= '0;
						round_q     <= '0;
						best_none_q <= 1'b1;
						best_sq_q   <= '0;
						best_x_q    <= '0;
						best_y_q    <= '0;
						run_q       <= 1'b1;
					end
					addr_q <= '0;
				end
				ST_SCAN: begin
					addr_q <= addr_q + ADDR_W'(1);
				end
				ST_DRAIN: begin
					if (min_done) begin
						if (round_end) begin
							round_q     <= '0;
							best_none_q <= 1'b1;
							best_sq_q   <= '0;
							best_x_q    <= '0;
							best_y_q    <= '0;
						end else begin
							round_q <= round_nx;
							if (take) begin
								best_none_q <= 1'b0;
								best_sq_q   <= min_sq;
								best_x_q    <= cand_x_q;
								best_y_q    <= cand_y_q;
							end
						end
					end
				end
				ST_EMIT: begin
					count_q <= count_nx;
					done_q  <= 1'b1;
					if (is_last) begin
						run_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cand_go) begin
			cand_x_q <= clamp_x;
			cand_y_q <= clamp_y;
			emit_x_q <= clamp_x;
			emit_y_q <= clamp_y;
		end else if ((state_q == ST_DRAIN) && min_done) begin
			emit_x_q <= take ? cand_x_q : best_x_q;
			emit_y_q <= take ? cand_y_q : best_y_q;
		end
		if (state_q == ST_EMIT) begin
			px_q   <= emit_x_q;
			py_q   <= emit_y_q;
			pidx_q <= count_q[ADDR_W-1:0];
			last_q <= is_last;
		end
	end

	assign rd_addr     = addr_q;
	assign wr_addr     = count_q[ADDR_W-1:0];
	assign wr_x        = emit_x_q;
	assign wr_y        = emit_y_q;
	assign sel_x       = cand_x_q;
	assign sel_y       = cand_y_q;
	assign done        = done_q;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign point_index = pidx_q;
	assign last_point  = last_q;

endmodule

FILE: rtl/best_candidate_point_sampler.sv
// Best-candidate point sampler: a candidate taken with an empty store goes straight to the write state.
// Otherwise a candidate keeps busy high through the scan of the N stored points: one stored point
// per cycle from the single read port, then through the read data, difference, square and minimum stages.
// A candidate that closes a round then passes through the write state, from which its result is registered.
// A new candidate is taken only while busy is low; start items and register writes never raise busy.
// Reset clears the sequencer, counters, round state and configuration registers; the point store is not cleared.
module best_candidate_point_sampler
	import bcs_pkg::*;
#(
	parameter int MAX_POINTS     = MAX_POINTS_DEF,
	parameter int COORD_BITS     = COORD_BITS_DEF,
	parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
	localparam int ADDR_W        = $clog2(MAX_POINTS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [APB_ADDR_W-1:0]        paddr,
	input  logic [APB_DATA_W-1:0]        pwdata,
	output logic [APB_DATA_W-1:0]        prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic                         kind,
	input  logic signed [COORD_BITS-1:0] cand_x,
	input  logic signed [COORD_BITS-1:0] cand_y,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic [ADDR_W-1:0]            point_index,
	output logic                         last_point
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int RND_W = $clog2(MAX_CANDIDATES + 1);
	localparam int SQ_W  = 2*COORD_BITS + 1;
	localparam int WC_W  = (CNT_W > WANTED_BITS) ? CNT_W : WANTED_BITS;
	localparam int CC_W  = (RND_W > CANDS_BITS) ? RND_W : CANDS_BITS;

	logic [WANTED_BITS-1:0] wanted_q;
	logic [CANDS_BITS-1:0]  cands_q;
	logic [HALF_BITS-1:0]   half_w_q;
	logic [HALF_BITS-1:0]   half_h_q;
	logic                   cfg_wr;
	logic [1:0]             reg_sel;
	logic [WC_W-1:0]        wanted_ext, wanted_lim;
	logic [CC_W-1:0]        cands_ext, cands_lim;
	logic [CNT_W-1:0]       wanted_eff;
	logic [RND_W-1:0]       cands_eff;

	scan_ctl_t                    scan_ctl;
	logic [ADDR_W-1:0]            rd_addr, wr_addr;
	logic                         wr_en;
	logic signed [COORD_BITS-1:0] wr_x, wr_y, rd_x, rd_y, sel_x, sel_y;
	logic [SQ_W-1:0]              min_sq;
	logic                         min_done;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= WANTED_RST;
			cands_q  <= CANDS_RST;
			half_w_q <= HALF_W_RST;
			half_h_q <= HALF_H_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_POINTS_WANTED: wanted_q <= pwdata[WANTED_BITS-1:0];
				REG_CANDS_ROUND:   cands_q  <= pwdata[CANDS_BITS-1:0];
				REG_HALF_WIDTH:    half_w_q <= pwdata[HALF_BITS-1:0];
				REG_HALF_HEIGHT:   half_h_q <= pwdata[HALF_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_POINTS_WANTED: prdata = APB_DATA_W'(wanted_q);
			REG_CANDS_ROUND:   prdata = APB_DATA_W'(cands_q);
			REG_HALF_WIDTH:    prdata = APB_DATA_W'(half_w_q);
			REG_HALF_HEIGHT:   prdata = APB_DATA_W'(half_h_q);
			default:           prdata = '0;
		endcase
	end

	always_comb begin
		wanted_ext = WC_W'(wanted_q);
		if (wanted_ext == '0) begin
			wanted_lim = WC_W'(1);
		end else if (wanted_ext > WC_W'(MAX_POINTS)) begin
			wanted_lim = WC_W'(MAX_POINTS);
		end else begin
			wanted_lim = wanted_ext;
		end
		cands_ext = CC_W'(cands_q);
		if (cands_ext == '0) begin
			cands_lim = CC_W'(1);
		end else if (cands_ext > CC_W'(MAX_CANDIDATES)) begin
			cands_lim = CC_W'(MAX_CANDIDATES);
		end else begin
			cands_lim = cands_ext;
		end
	end

	assign wanted_eff = wanted_lim[CNT_W-1:0];
	assign cands_eff  = cands_lim[RND_W-1:0];

	bcs_ctrl #(
		.MAX_POINTS     (MAX_POINTS),
		.COORD_BITS     (COORD_BITS),
		.MAX_CANDIDATES (MAX_CANDIDATES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.kind        (kind),
		.cand_x      (cand_x),
		.cand_y      (cand_y),
		.busy        (busy),
		.wanted_eff  (wanted_eff),
		.cands_eff   (cands_eff),
		.half_width  (half_w_q),
		.half_height (half_h_q),
		.scan_ctl    (scan_ctl),
		.rd_addr     (rd_addr),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_x        (wr_x),
		.wr_y        (wr_y),
		.sel_x       (sel_x),
		.sel_y       (sel_y),
		.min_sq      (min_sq),
		.min_done    (min_done),
		.done        (done),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_index (point_index),
		.last_point  (last_point)
	);

	bcs_point_mem #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_x    (wr_x),
		.wr_y    (wr_y),
		.rd_en   (scan_ctl.issue),
		.rd_addr (rd_addr),
		.rd_x    (rd_x),
		.rd_y    (rd_y)
	);

	bcs_dist #(
		.COORD_BITS (COORD_BITS)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.cand_x   (sel_x),
		.cand_y   (sel_y),
		.rd_x     (rd_x),
		.rd_y     (rd_y),
		.min_sq   (min_sq),
		.min_done (min_done)
	);

endmodule

FILE: rtl/bcs_checker.sv
// Port-level checks for the best-candidate sampler, attached to the top level by bind.
// Sees only the item handshake and the result strobe; depends on bcs_pkg.
module bcs_assert_checker
	import bcs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic kind,
	input logic busy,
	input logic done
);

	// A result always comes out of a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
	else $error("result strobe without preceding work");

	// A start item is handled in the cycle of its transfer.
	a_start_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_START)) |=> !busy)
	else $error("start item left the block busy");

	// No result appears in the cycle right after a transfer.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
	else $error("result too early after a transfer");

	// Results are single-cycle strobes, never back to back.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
	else $error("result strobe held for two cycles");

endmodule

bind best_candidate_point_sampler bcs_assert_checker u_bcs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.kind   (kind),
	.busy   (busy),
	.done   (done)
);

FILE: sim/bcs_checker.sv
`timescale 1ns / 1ps
// Checker for the best-candidate point sampler: watches register writes, item and point transfers.
// Keeps its own copy of the point store and round state, and compares every emitted point.
// Depends on bcs_pkg for the register map, widths and item kinds.
module bcs_checker
	import bcs_pkg::*;
(
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [APB_ADDR_W-1:0]            paddr,
	input  logic [APB_DATA_W-1:0]            pwdata,
	input  logic                             pready,
	input  logic                             start,
	input  logic                             busy,
	input  logic                             kind,
	input  logic signed [COORD_BITS_DEF-1:0] cand_x,
	input  logic signed [COORD_BITS_DEF-1:0] cand_y,
	input  logic                             done,
	input  logic signed [COORD_BITS_DEF-1:0] point_x,
	input  logic signed [COORD_BITS_DEF-1:0] point_y,
	input  logic [$clog2(MAX_POINTS_DEF)-1:0] point_index,
	input  logic                             last_point,
	output int                               fail_count,
	output int                               outstanding
);

	localparam int IDX_W = $clog2(MAX_POINTS_DEF);

	typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

	typedef struct packed {
		coord_t           x;
		coord_t           y;
		logic [IDX_W-1:0] idx;
		logic             last;
	} point_rec_t;

	point_rec_t             expected_points[$];
	coord_t                 store_x[MAX_POINTS_DEF];
	coord_t                 store_y[MAX_POINTS_DEF];
	int unsigned            stored;
	int unsigned            round_pos;
	longint unsigned        best_d;
	bit                     best_none;
	coord_t                 best_x;
	coord_t                 best_y;
	bit                     run_on;
	logic [WANTED_BITS-1:0] wanted_reg;
	logic [CANDS_BITS-1:0]  cands_reg;
	logic [HALF_BITS-1:0]   half_w_reg;
	logic [HALF_BITS-1:0]   half_h_reg;

	initial fail_count = 0;

	function automatic coord_t clamp_coord(coord_t v, logic [HALF_BITS-1:0] half);
		int lim;
		int top;
		lim = half;
		top = (1 << (COORD_BITS_DEF - 1)) - 1;
		if (lim > top)
			lim = top;
		if (v > lim)
			return coord_t'(lim);
		if (v < -lim)
			return coord_t'(-lim);
		return v;
	endfunction

	function automatic longint unsigned nearest_sq(coord_t x, coord_t y);
		longint unsigned nearest;
		longint unsigned d;
		longint          dx;
		longint          dy;
		int unsigned     i;
		nearest = '1;
		for (i = 0; i < stored; i++) begin
			dx = longint'(x) - longint'(store_x[i]);
			dy = longint'(y) - longint'(store_y[i]);
			d = dx * dx + dy * dy;
			if (d < nearest)
				nearest = d;
		end
		return nearest;
	endfunction

	task automatic record_point(coord_t x, coord_t y);
		point_rec_t  r;
		int unsigned w;
		r.idx = stored[IDX_W-1:0];
		if (stored < MAX_POINTS_DEF) begin
			store_x[stored] = x;
			store_y[stored] = y;
			stored++;
		end
		w = wanted_reg;
		if (w < 1)
			w = 1;
		if (w > MAX_POINTS_DEF)
			w = MAX_POINTS_DEF;
		r.last = (stored >= w);
		if (r.last)
			run_on = 1'b0;
		r.x = x;
		r.y = y;
		expected_points.push_back(r);
	endtask

	task automatic predict_item(logic k, coord_t cx, coord_t cy);
		coord_t          x;
		coord_t          y;
		coord_t          win_x;
		coord_t          win_y;
		longint unsigned d;
		int unsigned     c;
		if (k == KIND_START) begin
			stored = 0;
			round_pos = 0;
			best_d = 0;
			best_none = 1'b1;
			best_x = '0;
			best_y = '0;
			run_on = 1'b1;
			return;
		end
		if (!run_on)
			return;
		x = clamp_coord(cx, half_w_reg);
		y = clamp_coord(cy, half_h_reg);
		if (stored == 0) begin
			record_point(x, y);
			return;
		end
		d = nearest_sq(x, y);
		if (best_none || d > best_d) begin
			best_none = 1'b0;
			best_d = d;
			best_x = x;
			best_y = y;
		end
		round_pos++;
		c = cands_reg;
		if (c < 1)
			c = 1;
		if (c > MAX_CANDIDATES_DEF)
			c = MAX_CANDIDATES_DEF;
		if (round_pos >= c) begin
			win_x = best_x;
			win_y = best_y;
			round_pos = 0;
			best_none = 1'b1;
			best_d = 0;
			best_x = '0;
			best_y = '0;
			record_point(win_x, win_y);
		end
	endtask

	task automatic check_point();
		point_rec_t e;
		if (expected_points.size() == 0) begin
			if (fail_count < 10)
				$display("unexpected point transfer: x=%0d y=%0d index=%0d last=%0b",
					point_x, point_y, point_index, last_point);
			fail_count++;
		end else begin
			e = expected_points.pop_front();
			if (e.x !== point_x || e.y !== point_y || e.idx !== point_index ||
				e.last !== last_point) begin
				if (fail_count < 10)
					$display("point mismatch: expected x=%0d y=%0d index=%0d last=%0b, got x=%0d y=%0d index=%0d last=%0b",
						e.x, e.y, e.idx, e.last, point_x, point_y, point_index, last_point);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_points.delete();
			stored = 0;
			round_pos = 0;
			best_d = 0;
			best_none = 1'b1;
			best_x = '0;
			best_y = '0;
			run_on = 1'b0;
			wanted_reg = WANTED_RST;
			cands_reg = CANDS_RST;
			half_w_reg = HALF_W_RST;
			half_h_reg = HALF_H_RST;
			outstanding <= 0;
		end else begin
			if (done)
				check_point();
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_POINTS_WANTED: wanted_reg = pwdata[WANTED_BITS-1:0];
					REG_CANDS_ROUND:   cands_reg = pwdata[CANDS_BITS-1:0];
					REG_HALF_WIDTH:    half_w_reg = pwdata[HALF_BITS-1:0];
					REG_HALF_HEIGHT:   half_h_reg = pwdata[HALF_BITS-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				predict_item(kind, cand_x, cand_y);
			outstanding <= expected_points.size();
		end
	end

endmodule

FILE: sim/best_candidate_point_sampler_tb.sv
`timescale 1ns / 1ps
// Top of the best-candidate point sampler testbench: clock, reset, register writes and items.
// Depends on bcs_pkg, the block and bcs_checker, which predicts and compares every point.
module best_candidate_point_sampler_tb
	import bcs_pkg::*;
();

	localparam int SETTLE_CYCLES  = MAX_POINTS_DEF + 16;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 580;
	localparam int MAX_RUN_ITEMS  = 150;

	typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]   paddr = '0;
	logic [APB_DATA_W-1:0]   pwdata = '0;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;
	logic                    start = 1'b0;
	logic                    busy;
	logic                    kind = KIND_CAND;
	coord_t                  cand_x = '0;
	coord_t                  cand_y = '0;
	logic                    done;
	coord_t                  point_x;
	coord_t                  point_y;
	logic [$clog2(MAX_POINTS_DEF)-1:0] point_index;
	logic                    last_point;
	int                      fail_count;
	int                      outstanding;
	int                      idle_pct = 0;
	int                      quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	best_candidate_point_sampler dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .kind(kind), .cand_x(cand_x), .cand_y(cand_y),
		.done(done), .point_x(point_x), .point_y(point_y), .point_index(point_index),
		.last_point(last_point)
	);

	bcs_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.start(start), .busy(busy), .kind(kind), .cand_x(cand_x), .cand_y(cand_y),
		.done(done), .point_x(point_x), .point_y(point_y), .point_index(point_index),
		.last_point(last_point),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable && pwrite && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	task automatic cfg_write(logic [1:0] reg_idx, int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_config(int unsigned w, int unsigned c, int unsigned hw, int unsigned hh);
		cfg_write(REG_POINTS_WANTED, w);
		cfg_write(REG_CANDS_ROUND, c);
		cfg_write(REG_HALF_WIDTH, hw);
		cfg_write(REG_HALF_HEIGHT, hh);
	endtask

	task automatic drain_and_wait();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(logic k, coord_t x, coord_t y);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		cand_x <= x;
		cand_y <= y;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(9))
			0:       return 12'sh800;
			1:       return 12'sh7FF;
			default: return coord_t'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic int unsigned rand_half();
		case ($urandom_range(3))
			0:       return 0;
			1:       return 2047;
			default: return $urandom_range(0, 2047);
		endcase
	endfunction

	initial begin
		int sent;
		int seg;
		int run_len;
		int n;
		int unsigned w;
		int unsigned c;
		int unsigned weff;
		int unsigned ceff;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_config(4, 2, 2047, 2047);
		send_item(KIND_CAND, 100, 100);
		send_item(KIND_START, 0, 0);
		send_item(KIND_CAND, 0, 0);
		send_item(KIND_CAND, 3, 4);
		send_item(KIND_CAND, 5, 0);
		send_item(KIND_CAND, 12'sh800, 12'sh800);
		send_item(KIND_CAND, 12'sh7FF, 12'sh7FF);
		send_item(KIND_CAND, 12'sh7FF, 12'sh7FF);
		send_item(KIND_CAND, 12'sh7FF, 12'sh7FF);
		send_item(KIND_CAND, 1, 1);
		drain_and_wait();

		write_config(0, 0, 0, 0);
		send_item(KIND_START, 12'sh7FF, 12'sh800);
		send_item(KIND_CAND, -5, 7);
		send_item(KIND_CAND, 9, 9);
		drain_and_wait();

		write_config(2047, 127, 300, 1500);
		send_item(KIND_START, 0, 0);
		send_item(KIND_CAND, 12'sh800, 12'sh7FF);
		send_item(KIND_START, 0, 0);
		send_item(KIND_CAND, 1234, -1234);
		send_item(KIND_CAND, 0, 0);
		send_item(KIND_CAND, -1, -1);
		drain_and_wait();

		write_config(1, 1, 300, 1500);
		send_item(KIND_CAND, 7, -7);
		send_item(KIND_CAND, 8, 8);

		sent = 0;
		seg = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_and_wait();
			case (seg % 3)
				0:       idle_pct = 0;
				1:       idle_pct = 56;
				default: idle_pct = 26;
			endcase
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(3))
					0:       w = 0;
					1:       w = 1024;
					2:       w = 2047;
					default: w = $urandom_range(0, 2047);
				endcase
				case ($urandom_range(3))
					0:       c = 0;
					1:       c = 64;
					2:       c = 127;
					default: c = $urandom_range(0, 127);
				endcase
			end else begin
				w = $urandom_range(1, 24);
				c = $urandom_range(1, 8);
			end
			write_config(w, c, rand_half(), rand_half());
			weff = (w < 1) ? 1 : (w > MAX_POINTS_DEF) ? MAX_POINTS_DEF : w;
			ceff = (c < 1) ? 1 : (c > MAX_CANDIDATES_DEF) ? MAX_CANDIDATES_DEF : c;
			run_len = 1 + (weff - 1) * ceff;
			if (run_len > MAX_RUN_ITEMS)
				run_len = MAX_RUN_ITEMS;
			if (run_len > RANDOM_ITEMS - sent)
				run_len = RANDOM_ITEMS - sent;
			if ($urandom_range(3) != 0) begin
				send_item(KIND_START, rand_coord(), rand_coord());
				sent++;
			end
			for (n = 0; n < run_len; n++) begin
				if ($urandom_range(29) == 0) begin
					send_item(KIND_START, rand_coord(), rand_coord());
					sent++;
				end
				send_item(KIND_CAND, rand_coord(), rand_coord());
				sent++;
			end
			repeat ($urandom_range(3)) begin
				send_item(KIND_CAND, rand_coord(), rand_coord());
				sent++;
			end
			seg++;
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: sim.f
rtl/bcs_pkg.sv
rtl/bcs_point_mem.sv
rtl/bcs_dist.sv
rtl/bcs_ctrl.sv
rtl/best_candidate_point_sampler.sv
rtl/bcs_checker.sv
sim/bcs_checker.sv
sim/best_candidate_point_sampler_tb.sv
